FILE: hdl/ncs_pkg.sv
`timescale 1ns / 1ps

package ncs_pkg;

    // Default sizes of the centroid table.
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_DIMS_DEF     = 16;

    // Field widths.
    localparam int COORD_W  = 16;
    localparam int CI_W     = 4;
    localparam int DI_W     = 4;
    localparam int NC_W     = 4;
    localparam int DIST_W   = 36;
    localparam int MAG_W    = 16;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int CFG_W    = 5;
    localparam int CFG_A_W  = 1;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] REG_ACTIVE_CLUSTERS = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_ACTIVE_DIMS     = 1'b1;
    localparam logic [CFG_W-1:0]   CFG_RESET           = 5'd16;

    // Input item kinds carried on tuser.
    localparam logic OP_CENTROID = 1'b0;
    localparam logic OP_POINT    = 1'b1;

    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam dist_t DIST_MAX = {DIST_W{1'b1}};

    // Control that travels alongside one centroid through the distance pipeline.
    typedef struct packed {
        logic vld;
        logic last;
    } ncs_tag_t;

endpackage

FILE: hdl/ncs_centroid_mem.sv
`timescale 1ns / 1ps

// Centroid coordinate table: one write port, one registered read port.
module ncs_centroid_mem #(
    parameter int DEPTH = ncs_pkg::MAX_CLUSTERS_DEF * ncs_pkg::MAX_DIMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  ncs_pkg::coord_t        wdata,
    input  logic [AW-1:0]          raddr,
    output ncs_pkg::coord_t        rdata
);

    ncs_pkg::coord_t mem [DEPTH];
    ncs_pkg::coord_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/ncs_acc_mem.sv
`timescale 1ns / 1ps

// Distance accumulators. Each entry has a valid bit; an entry that is not
// valid reads as zero, so clearing all sums only takes resetting the valid bits.
module ncs_acc_mem #(
    parameter int DEPTH = ncs_pkg::MAX_CLUSTERS_DEF,
    parameter int KW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            we,
    input  logic [KW-1:0]   waddr,
    input  ncs_pkg::dist_t  wdata,
    input  logic [KW-1:0]   raddr,
    output ncs_pkg::dist_t  rdata
);

    ncs_pkg::dist_t   mem [DEPTH];
    ncs_pkg::dist_t   rdata_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= vld_reg[raddr];
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

FILE: hdl/ncs_dist_pipe.sv
`timescale 1ns / 1ps

// Three-stage distance datapath: absolute difference, square, saturating
// accumulate. The tag enters in the cycle the memory reads are issued, the
// cycle before the read data.
module ncs_dist_pipe #(
    parameter int KW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ncs_pkg::ncs_tag_t tag_in,
    input  logic [KW-1:0]     k_in,
    input  ncs_pkg::coord_t   cent,
    input  ncs_pkg::dist_t    acc,
    input  ncs_pkg::coord_t   point,
    output ncs_pkg::ncs_tag_t tag_out,
    output logic [KW-1:0]     k_out,
    output ncs_pkg::dist_t    sum
);

    ncs_pkg::ncs_tag_t t1_reg, t2_reg, t3_reg;
    logic [KW-1:0]     k1_reg, k2_reg, k3_reg;

    logic [ncs_pkg::MAG_W-1:0] mag_reg;
    logic [ncs_pkg::SQ_W-1:0]  sq_reg;
    ncs_pkg::dist_t            acc2_reg, acc3_reg;

    logic signed [ncs_pkg::COORD_W:0] diff;
    logic [ncs_pkg::COORD_W:0]        diff_abs;
    logic [ncs_pkg::DIST_W:0]         sum_wide;

    always_comb
    begin
        diff     = {cent[ncs_pkg::COORD_W-1], cent} - {point[ncs_pkg::COORD_W-1], point};
        diff_abs = diff[ncs_pkg::COORD_W] ? (~diff + 1'b1) : diff;
        sum_wide = {1'b0, acc3_reg} + {{(ncs_pkg::DIST_W + 1 - ncs_pkg::SQ_W){1'b0}}, sq_reg};
        sum      = sum_wide[ncs_pkg::DIST_W] ? ncs_pkg::DIST_MAX
                                             : sum_wide[ncs_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end
        else
        begin
            t1_reg <= tag_in;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg   <= k_in;
        k2_reg   <= k1_reg;
        k3_reg   <= k2_reg;
        mag_reg  <= diff_abs[ncs_pkg::MAG_W-1:0];
        acc2_reg <= acc;
        sq_reg   <= mag_reg * mag_reg;
        acc3_reg <= acc2_reg;
    end

    assign tag_out = t3_reg;
    assign k_out   = k3_reg;

endmodule

FILE: hdl/nearest_centroid_search.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents (lowest bit first)
// s_*       in         tdata: cluster_index[3:0], dim_index[7:4], coord_value[23:8]
//                      tuser: op (0 = centroid coordinate, 1 = point coordinate)
// m_*       out        tdata: nearest_cluster[3:0], min_distance_sq[39:4]
// cfg_*     in         cfg_addr 0 = active_clusters, 1 = active_dims; data in cfg_wdata
//
// A centroid coordinate beat is written to the table in the cycle it is accepted.
// A point coordinate beat sweeps the accumulator memory once, one centroid per
// cycle, through a three-stage distance pipeline; a beat that completes a point
// then also passes through the EMIT state.
// Reset clears control state, the accumulator valid bits and both registers
// (to 16); the centroid table holds garbage until written.
// The input waits while a point coordinate is in flight. A finished result moves
// into the output register as soon as that register is free, so a stalled
// output only holds the block once a second result is ready.
module nearest_centroid_search #(
    parameter int MAX_CLUSTERS = ncs_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_DIMS     = ncs_pkg::MAX_DIMS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ncs_pkg::IN_TDATA_W-1:0]      s_tdata,  // cluster_index, dim_index, coord_value
    input  logic                                s_tuser,  // op
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ncs_pkg::OUT_TDATA_W-1:0]     m_tdata,  // nearest_cluster, min_distance_sq
    // Configuration
    input  logic                                cfg_we,
    input  logic [ncs_pkg::CFG_A_W-1:0]         cfg_addr,
    input  logic [ncs_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(MAX_CLUSTERS);
    localparam int NKW   = $clog2(MAX_CLUSTERS + 1);
    localparam int NDW   = $clog2(MAX_DIMS + 1);

    typedef enum logic [1:0] {IDLE, RUN, EMIT} state_t;

    state_t state_reg, state_next;

    logic [ncs_pkg::CFG_W-1:0] clusters_reg, dims_reg;
    logic [NKW-1:0]            nk;
    logic [NDW-1:0]            nd;

    logic [KW-1:0]             k_reg, k_next;
    logic                      issuing_reg, issuing_next;
    logic [ncs_pkg::DI_W-1:0]  di_reg, di_next;
    ncs_pkg::coord_t           val_reg, val_next;
    logic                      final_reg, final_next;
    ncs_pkg::dist_t            best_reg, best_next;
    logic [KW-1:0]             best_k_reg, best_k_next;
    logic                      out_vld_reg, out_vld_next;
    logic [ncs_pkg::NC_W-1:0]  out_nc_reg, out_nc_next;
    ncs_pkg::dist_t            out_dist_reg, out_dist_next;

    // Input beat fields.
    logic                      in_op;
    logic [ncs_pkg::CI_W-1:0]  in_ci;
    logic [ncs_pkg::DI_W-1:0]  in_di;
    ncs_pkg::coord_t           in_val;
    logic                      in_acc;

    logic                      k_last;
    logic                      cent_we;
    logic [AW-1:0]             cent_waddr, cent_raddr;
    ncs_pkg::coord_t           cent_rdata;
    logic                      acc_clear;
    ncs_pkg::dist_t            acc_rdata;
    ncs_pkg::ncs_tag_t         tag_in, tag_out;
    logic [KW-1:0]             k_out;
    ncs_pkg::dist_t            sum;

    assign in_op  = s_tuser;
    assign in_ci  = s_tdata[3:0];
    assign in_di  = s_tdata[7:4];
    assign in_val = s_tdata[23:8];
    assign in_acc = s_tvalid && s_tready;

    // Out-of-range register values act as the nearest legal count.
    always_comb
    begin
        if (clusters_reg == '0)
        begin
            nk = NKW'(1);
        end
        else if (int'(clusters_reg) > MAX_CLUSTERS)
        begin
            nk = NKW'(MAX_CLUSTERS);
        end
        else
        begin
            nk = NKW'(clusters_reg);
        end

        if (dims_reg == '0)
        begin
            nd = NDW'(1);
        end
        else if (int'(dims_reg) > MAX_DIMS)
        begin
            nd = NDW'(MAX_DIMS);
        end
        else
        begin
            nd = NDW'(dims_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= ncs_pkg::CFG_RESET;
            dims_reg     <= ncs_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ncs_pkg::REG_ACTIVE_CLUSTERS: clusters_reg <= cfg_wdata;
                ncs_pkg::REG_ACTIVE_DIMS:     dims_reg     <= cfg_wdata;
                default:                      ;
            endcase
        end
    end

    // Centroid writes outside the table are dropped.
    assign cent_we    = in_acc && (in_op == ncs_pkg::OP_CENTROID)
                        && (int'(in_ci) < MAX_CLUSTERS) && (int'(in_di) < MAX_DIMS);
    assign cent_waddr = AW'(in_ci) * AW'(MAX_DIMS) + AW'(in_di);
    assign cent_raddr = AW'(k_reg) * AW'(MAX_DIMS) + AW'(di_reg);

    assign k_last = (int'(k_reg) == int'(nk) - 1);

    assign tag_in.vld  = (state_reg == RUN) && issuing_reg;
    assign tag_in.last = k_last;

    ncs_centroid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_cent (
        .clk   (clk),
        .we    (cent_we),
        .waddr (cent_waddr),
        .wdata (in_val),
        .raddr (cent_raddr),
        .rdata (cent_rdata)
    );

    ncs_acc_mem #(
        .DEPTH (MAX_CLUSTERS),
        .KW    (KW)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (acc_clear),
        .we    (tag_out.vld),
        .waddr (k_out),
        .wdata (sum),
        .raddr (k_reg),
        .rdata (acc_rdata)
    );

    ncs_dist_pipe #(
        .KW (KW)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_in),
        .k_in    (k_reg),
        .cent    (cent_rdata),
        .acc     (acc_rdata),
        .point   (val_reg),
        .tag_out (tag_out),
        .k_out   (k_out),
        .sum     (sum)
    );

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        issuing_next  = issuing_reg;
        di_next       = di_reg;
        val_next      = val_reg;
        final_next    = final_reg;
        best_next     = best_reg;
        best_k_next   = best_k_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_nc_next   = out_nc_reg;
        out_dist_next = out_dist_reg;
        acc_clear     = 1'b0;

        case (state_reg)
            IDLE:
            begin
                // A point coordinate beyond the active dimensions is dropped.
                if (in_acc && (in_op == ncs_pkg::OP_POINT) && (int'(in_di) < int'(nd)))
                begin
                    state_next   = RUN;
                    k_next       = '0;
                    issuing_next = 1'b1;
                    di_next      = in_di;
                    val_next     = in_val;
                    final_next   = (int'(in_di) == int'(nd) - 1);
                    // The first coordinate of a point starts every sum at zero.
                    acc_clear    = (in_di == '0);
                end
            end

            RUN:
            begin
                if (issuing_reg)
                begin
                    if (k_last)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end

                if (tag_out.vld)
                begin
                    // Strict less-than keeps the lowest index on a tie.
                    if ((k_out == '0) || (sum < best_reg))
                    begin
                        best_next   = sum;
                        best_k_next = k_out;
                    end
                    if (tag_out.last)
                    begin
                        if (final_reg)
                        begin
                            acc_clear  = 1'b1;
                            state_next = EMIT;
                        end
                        else
                        begin
                            state_next = IDLE;
                        end
                    end
                end
            end

            EMIT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_nc_next   = ncs_pkg::NC_W'(best_k_reg);
                    out_dist_next = best_reg;
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            issuing_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        di_reg       <= di_next;
        val_reg      <= val_next;
        final_reg    <= final_next;
        best_reg     <= best_next;
        best_k_reg   <= best_k_next;
        out_nc_reg   <= out_nc_next;
        out_dist_reg <= out_dist_next;
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_dist_reg, out_nc_reg};

    // The sweep never addresses a centroid beyond the active count.
    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN && issuing_reg) |-> (int'(k_reg) < int'(nk)))
        else $error("centroid sweep ran past the active cluster count");

    // A coordinate is finished only after every read has been issued.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN && state_next != RUN) |-> !issuing_reg)
        else $error("coordinate finished while reads were still being issued");

    // The reported centroid is one of the active ones.
    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EMIT) |-> (int'(best_k_reg) < int'(nk)))
        else $error("nearest centroid index outside the active set");

    // The datapath is empty whenever the block waits for input.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) |-> !tag_out.vld)
        else $error("accumulator write while idle");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the nearest-centroid search block.
// Beats are driven on the falling clock edge. A monitor samples both streams and the
// configuration port on the rising edge. Every accepted input beat goes through a
// local model of the assignment step. A beat that completes a point queues one
// expected result. Each result beat that the block delivers is checked against the
// oldest entry in that queue.
module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    // A point coordinate sweeps at most sixteen centroids, so this is ample.
    localparam int SETTLE_TICKS = 32;

    // Input beat layout, lowest bits last in the packed order: cluster, dim, coord.
    typedef struct packed {
        ncs_pkg::coord_t              coord;
        logic [ncs_pkg::DI_W-1:0]     dim;
        logic [ncs_pkg::CI_W-1:0]     cluster;
    } coord_beat_t;

    // Result beat layout: nearest_cluster in the low nibble, distance above it.
    typedef struct packed {
        ncs_pkg::dist_t               distance;
        logic [ncs_pkg::NC_W-1:0]     cluster;
    } nearest_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [ncs_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // cluster_index, dim_index, coord_value
    logic                            s_tuser   = 1'b0; // op
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [ncs_pkg::OUT_TDATA_W-1:0] m_tdata;          // nearest_cluster, min_distance_sq
    logic                            cfg_we    = 1'b0;
    logic [ncs_pkg::CFG_A_W-1:0]     cfg_addr  = '0;
    logic [ncs_pkg::CFG_W-1:0]       cfg_wdata = '0;

    nearest_centroid_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Model state. It is updated only from what the monitor sees accepted.
    ncs_pkg::coord_t  centroid_mirror [ncs_pkg::MAX_CLUSTERS_DEF][ncs_pkg::MAX_DIMS_DEF];
    ncs_pkg::dist_t   dist_acc [ncs_pkg::MAX_CLUSTERS_DEF];
    logic [ncs_pkg::CFG_W-1:0] clusters_reg = ncs_pkg::CFG_RESET;
    logic [ncs_pkg::CFG_W-1:0] dims_reg     = ncs_pkg::CFG_RESET;
    nearest_t         nearest_q[$];

    // Stimulus-side view. It records which table entries hold data, so that no point
    // ever reads an entry that was never written. It also keeps the effective
    // register values.
    bit               loaded [ncs_pkg::MAX_CLUSTERS_DEF][ncs_pkg::MAX_DIMS_DEF];
    int               stim_clusters = ncs_pkg::MAX_CLUSTERS_DEF;
    int               stim_dims     = ncs_pkg::MAX_DIMS_DEF;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               beats_sent = 0;
    int               errors = 0;
    int               cycles = 0;

    // A register value of zero acts as one. Values above the table size act as the size.
    function automatic int effective_count(input logic [ncs_pkg::CFG_W-1:0] v,
                                           input int max_count);
        if (v == 0)
            return 1;
        if (v > max_count)
            return max_count;
        return v;
    endfunction

    // Adds one point coordinate to every active accumulator. It returns 1 and the
    // winner when the coordinate is the last active one. Sums saturate at the 36-bit
    // maximum. On a tie the strict less-than keeps the lowest index.
    function automatic bit assign_coordinate(input logic [ncs_pkg::DI_W-1:0] di,
                                             input ncs_pkg::coord_t val,
                                             output nearest_t res);
        int                                nk;
        int                                nd;
        logic signed [ncs_pkg::COORD_W:0]  diff;
        logic [ncs_pkg::COORD_W:0]         mag;
        logic [ncs_pkg::DIST_W:0]          sum;
        nk  = effective_count(clusters_reg, ncs_pkg::MAX_CLUSTERS_DEF);
        nd  = effective_count(dims_reg, ncs_pkg::MAX_DIMS_DEF);
        res = '0;
        if (di >= nd)
            return 1'b0;
        // A coordinate at position zero always starts a new point from clean sums.
        if (di == 0)
            foreach (dist_acc[k])
                dist_acc[k] = '0;
        for (int k = 0; k < nk; k++)
        begin
            diff = centroid_mirror[k][di] - val;
            mag  = diff[ncs_pkg::COORD_W] ? -diff : diff;
            sum  = dist_acc[k] + mag * mag;
            dist_acc[k] = (sum > ncs_pkg::DIST_MAX) ? ncs_pkg::DIST_MAX
                                                    : sum[ncs_pkg::DIST_W-1:0];
        end
        if (di != nd - 1)
            return 1'b0;
        res.cluster  = '0;
        res.distance = dist_acc[0];
        for (int k = 1; k < nk; k++)
            if (dist_acc[k] < res.distance)
            begin
                res.distance = dist_acc[k];
                res.cluster  = ncs_pkg::NC_W'(k);
            end
        foreach (dist_acc[k])
            dist_acc[k] = '0;
        return 1'b1;
    endfunction

    // The monitor runs on the rising edge. It reads values from before the edge, so
    // the order of events inside the time step cannot change what it sees.
    always @(posedge clk)
    begin
        nearest_t    got;
        nearest_t    want;
        coord_beat_t beat;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (nearest_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: cluster %0d distance %0d",
                             $time, got.cluster, got.distance);
                    errors++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (got.cluster !== want.cluster)
                    begin
                        $display("%0t: nearest_cluster expected %0d actual %0d",
                                 $time, want.cluster, got.cluster);
                        errors++;
                    end
                    if (got.distance !== want.distance)
                    begin
                        $display("%0t: min_distance_sq expected %0d actual %0d",
                                 $time, want.distance, got.distance);
                        errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == ncs_pkg::REG_ACTIVE_CLUSTERS)
                    clusters_reg = cfg_wdata;
                else
                    dims_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready)
            begin
                beat = s_tdata;
                if (s_tuser == ncs_pkg::OP_CENTROID)
                    centroid_mirror[beat.cluster][beat.dim] = beat.coord;
                else if (assign_coordinate(beat.dim, beat.coord, want))
                    nearest_q = {nearest_q, want};
            end
        end
    end

    // The result side stalls at random, at the rate that the current phase sets.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // This watchdog ends a run that has hung.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Extreme values and small values come up often, so that ties and full-scale
    // differences occur. Everything else is uniform over the 16-bit range.
    function automatic ncs_pkg::coord_t rand_coord();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return ncs_pkg::coord_t'(int'($urandom_range(6)) - 3);
            default: return ncs_pkg::coord_t'($urandom);
        endcase
    endfunction

    // Sends one beat. It may idle first, then holds tvalid until the beat is accepted.
    // The task returns on the accepting rising edge. The next call or stop_sending
    // then owns the following falling edge, so tvalid is assigned once per time step.
    task automatic send_beat(input logic op, input logic [ncs_pkg::CI_W-1:0] ci,
                             input logic [ncs_pkg::DI_W-1:0] di,
                             input ncs_pkg::coord_t val);
        coord_beat_t beat;
        beat = '{coord: val, dim: di, cluster: ci};
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= beat;
        if (op == ncs_pkg::OP_CENTROID)
            loaded[ci][di] = 1'b1;
        beats_sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // A point coordinate that the block will use reads column di of every active
    // centroid. Any entry of that column that has never been written is filled first.
    // The cluster field is ignored on point beats, so it carries random bits.
    task automatic send_point(input logic [ncs_pkg::DI_W-1:0] di, input ncs_pkg::coord_t val);
        if (di < stim_dims)
            for (int k = 0; k < stim_clusters; k++)
                if (!loaded[k][di])
                    send_beat(ncs_pkg::OP_CENTROID, ncs_pkg::CI_W'(k), di, rand_coord());
        send_beat(ncs_pkg::OP_POINT, ncs_pkg::CI_W'($urandom), di, val);
    endtask

    // Sends coordinates 0 .. len-1 of one point. Now and then a centroid write comes
    // before a coordinate. When len is short of active_dims, the point is left
    // unfinished.
    task automatic send_point_run(input int len);
        for (int d = 0; d < len; d++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(ncs_pkg::OP_CENTROID, ncs_pkg::CI_W'($urandom),
                          ncs_pkg::DI_W'($urandom), rand_coord());
            send_point(ncs_pkg::DI_W'(d), rand_coord());
        end
    endtask

    // Waits until every expected result has come back. A trailing coordinate that
    // gives no result may still be working its way through the pipeline, so the task
    // then waits a while longer.
    task automatic settle();
        stop_sending();
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ncs_pkg::CFG_A_W-1:0] addr,
                             input logic [ncs_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (addr == ncs_pkg::REG_ACTIVE_CLUSTERS)
            stim_clusters = effective_count(value, ncs_pkg::MAX_CLUSTERS_DEF);
        else
            stim_dims = effective_count(value, ncs_pkg::MAX_DIMS_DEF);
    endtask

    // Register values used in random phases. The out-of-range values 0 and 17..31
    // are included, and small sizes are favored so that results come often.
    function automatic logic [ncs_pkg::CFG_W-1:0] pick_reg();
        case ($urandom_range(9))
            0:       return 5'd0;
            1:       return 5'd31;
            2:       return 5'd1;
            3:       return 5'd16;
            4:       return ncs_pkg::CFG_W'($urandom_range(17, 30));
            5, 6:    return ncs_pkg::CFG_W'($urandom_range(1, 16));
            default: return ncs_pkg::CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Two centroids at opposite corners. The first two points each land exactly on one of them.
    // The test also covers an ignored coordinate beyond active_dims, a lone last
    // coordinate, a tie that must pick the lower index, and a centroid write in the
    // middle of a point.
    task automatic test_directed_cases();
        write_reg(ncs_pkg::REG_ACTIVE_CLUSTERS, 5'd2);
        write_reg(ncs_pkg::REG_ACTIVE_DIMS, 5'd2);
        send_beat(ncs_pkg::OP_CENTROID, 4'd0, 4'd0, 16'sh8000);
        send_beat(ncs_pkg::OP_CENTROID, 4'd0, 4'd1, 16'sh7FFF);
        send_beat(ncs_pkg::OP_CENTROID, 4'd1, 4'd0, 16'sh7FFF);
        send_beat(ncs_pkg::OP_CENTROID, 4'd1, 4'd1, 16'sh8000);
        send_point(4'd0, 16'sh7FFF);
        send_point(4'd1, 16'sh8000);
        send_point(4'd0, 16'sh8000);
        send_point(4'd1, 16'sh7FFF);
        send_point(4'd3, 16'sh1234);
        send_point(4'd1, 16'sh0000);
        // Make centroid 1 equal to centroid 0, then measure from the origin.
        send_beat(ncs_pkg::OP_CENTROID, 4'd1, 4'd0, 16'sh8000);
        send_beat(ncs_pkg::OP_CENTROID, 4'd1, 4'd1, 16'sh7FFF);
        send_point(4'd0, 16'sh0000);
        send_point(4'd1, 16'sh0000);
        send_point(4'd0, 16'sh0000);
        send_beat(ncs_pkg::OP_CENTROID, 4'd1, 4'd1, 16'sh0000);
        send_point(4'd1, 16'sh0000);
        settle();
    endtask

    // With one active centroid, seventeen full-scale squares exceed 36 bits, so the
    // reported distance must saturate. Coordinate 1 is repeated to get there.
    task automatic test_saturation();
        write_reg(ncs_pkg::REG_ACTIVE_CLUSTERS, 5'd1);
        write_reg(ncs_pkg::REG_ACTIVE_DIMS, 5'd16);
        send_beat(ncs_pkg::OP_CENTROID, 4'd0, 4'd0, 16'sh8000);
        send_beat(ncs_pkg::OP_CENTROID, 4'd0, 4'd1, 16'sh8000);
        send_beat(ncs_pkg::OP_CENTROID, 4'd0, 4'd15, 16'sh8000);
        send_point(4'd0, 16'sh7FFF);
        repeat (15) send_point(4'd1, 16'sh7FFF);
        send_point(4'd15, 16'sh7FFF);
        settle();
    endtask

    // Both registers at their limits and beyond. Zero acts as one, and 17 or more
    // acts as sixteen.
    task automatic test_register_extremes();
        logic [ncs_pkg::CFG_W-1:0] k_vals [5] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd5};
        logic [ncs_pkg::CFG_W-1:0] d_vals [5] = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17};
        for (int i = 0; i < 5; i++)
        begin
            write_reg(ncs_pkg::REG_ACTIVE_CLUSTERS, k_vals[i]);
            write_reg(ncs_pkg::REG_ACTIVE_DIMS, d_vals[i]);
            send_point_run(stim_dims);
            settle();
        end
    endtask

    // Mostly complete points with random content under changing settings. The rest is
    // noise: stray centroid writes, lone coordinates at any position (some beyond
    // active_dims) and points left unfinished.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int stop_at;
        int next_cfg;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at  = beats_sent + n;
        next_cfg = beats_sent;
        while (beats_sent < stop_at)
        begin
            if (beats_sent >= next_cfg)
            begin
                settle();
                write_reg(ncs_pkg::REG_ACTIVE_CLUSTERS, pick_reg());
                write_reg(ncs_pkg::REG_ACTIVE_DIMS, pick_reg());
                next_cfg = beats_sent + 45;
            end
            pick = $urandom_range(99);
            if (pick < 75)
                send_point_run(stim_dims);
            else if (pick < 85)
                send_beat(ncs_pkg::OP_CENTROID, ncs_pkg::CI_W'($urandom),
                          ncs_pkg::DI_W'($urandom), rand_coord());
            else if (pick < 92)
                send_point(ncs_pkg::DI_W'($urandom), rand_coord());
            else
                send_point_run($urandom_range(0, stim_dims - 1));
        end
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_saturation();
        test_register_extremes();
        test_random_traffic(0, 0, 50);
        test_random_traffic(53, 0, 50);
        test_random_traffic(0, 53, 50);
        test_random_traffic(10, 10, 50);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
